// ===== rtl/core/slope_zenith_sin_cos_unit_core_assert.svh =====
// Assertion macros for the slope/zenith sine-cosine core.
// Used by the checker bound to the top level; no other dependencies.
`ifndef SLOPE_ZENITH_SIN_COS_UNIT_CORE_ASSERT_SVH
`define SLOPE_ZENITH_SIN_COS_UNIT_CORE_ASSERT_SVH

// Checked at clk_i edges outside reset.
`define SZSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every clk_i edge, reset included.
`define SZSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/szsc_pkg.sv =====
// Types, constants and helper functions of the slope/zenith sine-cosine core.
// No dependencies.
package szsc_pkg;

  localparam int unsigned SQRT_STEPS   = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned XW           = 34;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // a = 46603*deg + floor((17*deg + 22) / 45), the quotient by reciprocal
  localparam logic [31:0] ANG_MUL   = 32'd46603;
  localparam logic [42:0] RECIP_45  = 43'd2982617;
  localparam int unsigned RECIP_SH  = 27;

  typedef enum logic {
    REQ_SLOPE  = 1'b0,
    REQ_ZENITH = 1'b1
  } req_e;

  typedef struct packed {
    req_e                   req;
    logic                   deg_mode;
    logic                   flip;
    logic signed [15:0]     uv;
    logic [31:0]            rem;
    logic [31:0]            root;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [XW-1:0]   z;
  } iter_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sd32767;
    end else if (v < -20'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/szsc_if.sv =====
// Channel interfaces of the slope/zenith sine-cosine core: request and result words.
// No dependencies.
interface szsc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] unit_value;
  logic [15:0]        angle_deg;

  modport source (output valid, req_type, unit_value, angle_deg, input ready);
  modport sink   (input valid, req_type, unit_value, angle_deg, output ready);
endinterface

interface szsc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sin_out;
  logic signed [15:0] cos_out;

  modport source (output valid, sin_out, cos_out, input ready);
  modport sink   (input valid, sin_out, cos_out, output ready);
endinterface

// ===== rtl/core/szsc_iter.sv =====
// One pipeline stage: a square-root digit step and a CORDIC rotation step, each enabled by a parameter.
// Depends on szsc_pkg.
module szsc_iter #(
  parameter int unsigned Idx    = 0,
  parameter bit          DoRoot = 1'b1,
  parameter bit          DoRot  = 1'b1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  szsc_pkg::iter_t  data_i,
  output logic             valid_o,
  output szsc_pkg::iter_t  data_o
);

  localparam int unsigned RootSh  = DoRoot ? (30 - 2 * Idx) : 0;
  localparam logic [31:0] RootBit = 32'd1 << RootSh;

  szsc_pkg::iter_t                 data_d;
  szsc_pkg::iter_t                 data_q;
  logic                            valid_q;
  logic [31:0]                     trial;
  logic signed [szsc_pkg::XW-1:0]  dx;
  logic signed [szsc_pkg::XW-1:0]  dy;
  logic signed [szsc_pkg::XW-1:0]  ang;

  always_comb begin
    data_d = data_i;
    trial  = data_i.root + RootBit;
    dx     = data_i.y >>> Idx;
    dy     = data_i.x >>> Idx;
    ang    = signed'({2'b00, szsc_pkg::atan_turn(5'(Idx))});
    if (DoRoot) begin
      if (data_i.rem >= trial) begin
        data_d.rem  = data_i.rem - trial;
        data_d.root = (data_i.root >> 1) + RootBit;
      end else begin
        data_d.root = data_i.root >> 1;
      end
    end
    if (DoRot) begin
      if (!data_i.z[szsc_pkg::XW-1]) begin
        data_d.x = data_i.x - dx;
        data_d.y = data_i.y + dy;
        data_d.z = data_i.z - ang;
      end else begin
        data_d.x = data_i.x + dx;
        data_d.y = data_i.y - dy;
        data_d.z = data_i.z + ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/slope_zenith_sin_cos_unit_core.sv =====
// Top level of the slope/zenith sine-cosine core: front stages, stage chain, output register.
// Depends on szsc_pkg, szsc_if and szsc_iter.
//
//   channel  | dir | handshake    | word
//   req_i    | in  | valid/ready  | req_type, unit_value, angle_deg
//   res_o    | out | valid/ready  | sin_out, cos_out
//   cfg      | in  | cfg_we_i     | cfg_wdata_i (zenith_in_degrees)
//
// One word per cycle while the output register is not stalled; a word passes front stages A
// and B, the chain of square-root digit and CORDIC stages and the output register.
// rst_ni clears all valid bits and the mode register to cosine mode.
// A full output register that is not taken freezes the whole chain; req_i.ready drops with it.
module slope_zenith_sin_cos_unit_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  szsc_req_if.sink    req_i,
  szsc_res_if.source  res_o
);

  localparam int unsigned RotSteps = (CORDIC_STAGES > szsc_pkg::ATAN_ENTRIES) ?
                                     szsc_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int unsigned Depth    = (RotSteps > szsc_pkg::SQRT_STEPS) ?
                                     RotSteps : szsc_pkg::SQRT_STEPS;

  logic                deg_mode_q;
  logic                en;

  // front stage A
  logic                a_valid_q;
  szsc_pkg::req_e      a_req_q;
  logic                a_mode_q;
  logic signed [15:0]  a_uv_q;
  logic signed [31:0]  a_sq_q;
  logic [31:0]         a_p1_q;
  logic [42:0]         a_p2_q;
  logic [20:0]         ang_num;

  // front stage B
  logic                b_valid_q;
  szsc_pkg::iter_t     b_d;
  szsc_pkg::iter_t     b_q;
  logic [31:0]         turn;
  logic                flip;

  logic                stg_valid [Depth+1];
  szsc_pkg::iter_t     stg_data  [Depth+1];

  // output stage
  szsc_pkg::iter_t                 fin;
  logic [31:0]                     root_f;
  logic signed [15:0]              root_s;
  logic signed [szsc_pkg::XW-1:0]  xr;
  logic signed [szsc_pkg::XW-1:0]  yr;
  logic signed [19:0]              xs;
  logic signed [19:0]              ys;
  logic signed [15:0]              sin_d;
  logic signed [15:0]              cos_d;
  logic                            res_valid_q;
  logic signed [15:0]              res_sin_q;
  logic signed [15:0]              res_cos_q;

  assign en          = !res_valid_q || res_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      deg_mode_q <= cfg_wdata_i;
    end
  end

  assign ang_num = {1'b0, req_i.angle_deg, 4'b0000} + {5'b00000, req_i.angle_deg} + 21'd22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= req_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_req_q  <= szsc_pkg::req_e'(req_i.req_type);
      a_mode_q <= deg_mode_q;
      a_uv_q   <= req_i.unit_value;
      a_sq_q   <= 32'(req_i.unit_value) * 32'(req_i.unit_value);
      a_p1_q   <= 32'(req_i.angle_deg) * szsc_pkg::ANG_MUL;
      a_p2_q   <= 43'(ang_num) * szsc_pkg::RECIP_45;
      b_q      <= b_d;
    end
  end

  always_comb begin
    turn          = a_p1_q + 32'(a_p2_q[42:szsc_pkg::RECIP_SH]);
    flip          = turn[31] ^ turn[30];
    b_d.req       = a_req_q;
    b_d.deg_mode  = a_mode_q;
    b_d.flip      = flip;
    b_d.uv        = a_uv_q;
    b_d.rem       = 32'd1073741824 - unsigned'(a_sq_q);
    b_d.root      = '0;
    b_d.x         = szsc_pkg::CORDIC_GAIN;
    b_d.y         = '0;
    b_d.z         = signed'({{2{turn[31] ^ flip}}, turn[31] ^ flip, turn[30:0]});
  end

  assign stg_valid[0] = b_valid_q;
  assign stg_data[0]  = b_q;

  for (genvar i = 0; i < Depth; i++) begin : g_stage
    szsc_iter #(
      .Idx    (i),
      .DoRoot (i < szsc_pkg::SQRT_STEPS),
      .DoRot  (i < RotSteps)
    ) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stg_valid[i]),
      .data_i  (stg_data[i]),
      .valid_o (stg_valid[i+1]),
      .data_o  (stg_data[i+1])
    );
  end

  always_comb begin
    fin    = stg_data[Depth];
    root_f = (fin.rem > fin.root) ? fin.root + 32'd1 : fin.root;
    root_s = (root_f > 32'd32767) ? 16'sd32767 : signed'(root_f[15:0]);
    xr     = (fin.x + 34'sd16384) >>> 15;
    yr     = (fin.y + 34'sd16384) >>> 15;
    xs     = fin.flip ? -xr[19:0] : xr[19:0];
    ys     = fin.flip ? -yr[19:0] : yr[19:0];
    if (fin.req == szsc_pkg::REQ_SLOPE) begin
      sin_d = fin.uv;
      cos_d = root_s;
    end else if (!fin.deg_mode) begin
      sin_d = root_s;
      cos_d = fin.uv;
    end else begin
      sin_d = szsc_pkg::sat16(ys);
      cos_d = szsc_pkg::sat16(xs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= stg_valid[Depth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_sin_q <= sin_d;
      res_cos_q <= cos_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.sin_out = res_sin_q;
  assign res_o.cos_out = res_cos_q;

endmodule

// ===== rtl/core/szsc_check.sv =====
// Port-level checker for the slope/zenith sine-cosine core, bound to the top level.
// Depends on slope_zenith_sin_cos_unit_core_assert.svh.
`include "slope_zenith_sin_cos_unit_core_assert.svh"

module szsc_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [15:0] sin_out_i,
  input logic [15:0] cos_out_i
);

  `SZSC_ASSERT_RST(a_rst_empty, !rst_ni |-> !res_valid_i, "result valid during reset")
  `SZSC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(sin_out_i) && $stable(cos_out_i), "stalled result word changed")
  `SZSC_ASSERT(a_ready_empty, !res_valid_i |-> req_ready_i, "not ready with empty output")
  `SZSC_ASSERT(a_ready_taken, res_valid_i && res_ready_i |-> req_ready_i, "not ready while result is taken")

endmodule

bind slope_zenith_sin_cos_unit_core szsc_check u_szsc_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .sin_out_i   (res_o.sin_out),
  .cos_out_i   (res_o.cos_out)
);
